// File: hw/rtl/etl_pkg.sv
// Shared types, constants and helper functions for the expression token lexer.
// Depends on nothing; every other file of the lexer imports it.
package etl_pkg;

	// Width of the character position counters.
	localparam int POS_BITS = 16;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	// Depth of the token pair queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// Characters with a role of their own.
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Item function codes.
	localparam logic FUNC_CHAR = 1'b0;
	localparam logic FUNC_END  = 1'b1;

	typedef enum logic [4:0] {
		KIND_NUM   = 5'd0,
		KIND_IDENT = 5'd1,
		KIND_EQ    = 5'd2,
		KIND_GT    = 5'd3,
		KIND_GE    = 5'd4,
		KIND_LT    = 5'd5,
		KIND_LE    = 5'd6,
		KIND_PLUS  = 5'd7,
		KIND_MINUS = 5'd8,
		KIND_STAR  = 5'd9,
		KIND_SLASH = 5'd10,
		KIND_CARET = 5'd11,
		KIND_LPAR  = 5'd12,
		KIND_RPAR  = 5'd13,
		KIND_COMMA = 5'd14,
		KIND_END   = 5'd15,
		KIND_ERR   = 5'd16
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_INT   = 3'd1,
		MODE_FRAC  = 3'd2,
		MODE_IDENT = 3'd3,
		MODE_DOT   = 3'd4,
		MODE_GT    = 3'd5,
		MODE_LT    = 3'd6,
		MODE_DRAIN = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		CLS_SPACE  = 3'd0,
		CLS_DIGIT  = 3'd1,
		CLS_DOT    = 3'd2,
		CLS_ALPHA  = 3'd3,
		CLS_GT     = 3'd4,
		CLS_LT     = 3'd5,
		CLS_SINGLE = 3'd6,
		CLS_BAD    = 3'd7
	} char_class_t;

	typedef struct packed {
		logic       func;
		logic [7:0] ch;
	} in_item_t;

	typedef struct packed {
		kind_t       token_kind;
		logic [15:0] start_pos;
		logic [15:0] token_len;
		logic [7:0]  bad_char;
		logic        last_of_run;
	} out_token_t;

	// What one item leaves in the queue: one or two words.
	typedef struct packed {
		logic       two;
		out_token_t t0;
		out_token_t t1;
	} token_pair_t;

	// Sort a character into the class that drives the scanner.
	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t cls;
		cls = CLS_BAD;
		if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
			cls = CLS_SPACE;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			cls = CLS_DIGIT;
		end else if (c == CH_DOT) begin
			cls = CLS_DOT;
		end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
				|| c == CH_UNDER) begin
			cls = CLS_ALPHA;
		end else if (c == CH_GT) begin
			cls = CLS_GT;
		end else if (c == CH_LT) begin
			cls = CLS_LT;
		end else if (c == CH_EQ || c == CH_PLUS || c == CH_MINUS || c == CH_STAR
				|| c == CH_SLASH || c == CH_CARET || c == CH_LPAR || c == CH_RPAR
				|| c == CH_COMMA) begin
			cls = CLS_SINGLE;
		end
		return cls;
	endfunction

	// Token kind of a single-character operator.
	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_EQ:    k = KIND_EQ;
			CH_PLUS:  k = KIND_PLUS;
			CH_MINUS: k = KIND_MINUS;
			CH_STAR:  k = KIND_STAR;
			CH_SLASH: k = KIND_SLASH;
			CH_CARET: k = KIND_CARET;
			CH_LPAR:  k = KIND_LPAR;
			CH_RPAR:  k = KIND_RPAR;
			default:  k = KIND_COMMA;
		endcase
		return k;
	endfunction

	// Clamp a position or length to the sixteen bits of the result fields.
	function automatic logic [15:0] sat16(input logic [31:0] v);
		return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

// File: hw/rtl/etl_front.sv
// Front of the lexer: scanner state machine, one input word per cycle when fire is high.
// Produces a pair of one or two token words for each item that yields any; depends on etl_pkg.
module etl_front
	import etl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  in_item_t    item,
	output logic        pair_valid,
	output token_pair_t pair
);

	mode_t               mode_q, mode_d;
	logic [POS_BITS-1:0] start_q, start_d;
	logic [POS_BITS-1:0] pos_q, pos_d;
	logic [POS_BITS-1:0] len_c;
	char_class_t         cls_c;

	// Fresh-token handling of the current character.
	mode_t      fresh_mode_c;
	logic       fresh_start_c;
	logic       fresh_emit_c;
	out_token_t fresh_tok_c;

	// Token that closes the pending one, and its flag.
	logic       pre_emit_c;
	out_token_t pre_tok_c;
	logic       use_fresh_c;
	logic       end_emit_c;

	function automatic out_token_t mk_tok(input kind_t k, input logic [POS_BITS-1:0] s,
			input logic [POS_BITS-1:0] l, input logic [7:0] bad);
		out_token_t t;
		t.token_kind  = k;
		t.start_pos   = sat16(32'(s));
		t.token_len   = sat16(32'(l));
		t.bad_char    = bad;
		t.last_of_run = 1'b0;
		return t;
	endfunction

	assign cls_c = classify(item.ch);
	assign len_c = pos_q - start_q;

	// A character seen with nothing pending.
	always_comb begin
		fresh_mode_c  = MODE_IDLE;
		fresh_start_c = 1'b0;
		fresh_emit_c  = 1'b0;
		fresh_tok_c   = mk_tok(single_kind(item.ch), pos_q, POS_BITS'(1), 8'h00);
		unique case (cls_c)
			CLS_SPACE: begin
			end
			CLS_DIGIT: begin
				fresh_mode_c  = MODE_INT;
				fresh_start_c = 1'b1;
			end
			CLS_DOT: begin
				fresh_mode_c  = MODE_DOT;
				fresh_start_c = 1'b1;
			end
			CLS_ALPHA: begin
				fresh_mode_c  = MODE_IDENT;
				fresh_start_c = 1'b1;
			end
			CLS_GT: begin
				fresh_mode_c  = MODE_GT;
				fresh_start_c = 1'b1;
			end
			CLS_LT: begin
				fresh_mode_c  = MODE_LT;
				fresh_start_c = 1'b1;
			end
			CLS_SINGLE: begin
				fresh_emit_c = 1'b1;
			end
			default: begin
				fresh_mode_c = MODE_DRAIN;
				fresh_emit_c = 1'b1;
				fresh_tok_c  = mk_tok(KIND_ERR, pos_q, POS_BITS'(1), item.ch);
			end
		endcase
	end

	// Next state of the scanner.
	always_comb begin
		mode_d  = mode_q;
		start_d = start_q;
		pos_d   = pos_q;
		if (fire) begin
			if (item.func == FUNC_END) begin
				mode_d  = MODE_IDLE;
				start_d = '0;
				pos_d   = '0;
			end else begin
				pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + POS_BITS'(1);
				unique case (mode_q)
					MODE_INT: begin
						if (cls_c == CLS_DOT) begin
							mode_d = MODE_FRAC;
						end else if (cls_c != CLS_DIGIT) begin
							mode_d = fresh_mode_c;
							if (fresh_start_c) start_d = pos_q;
						end
					end
					MODE_FRAC: begin
						if (cls_c != CLS_DIGIT) begin
							mode_d = fresh_mode_c;
							if (fresh_start_c) start_d = pos_q;
						end
					end
					MODE_IDENT: begin
						if (cls_c != CLS_DIGIT && cls_c != CLS_ALPHA) begin
							mode_d = fresh_mode_c;
							if (fresh_start_c) start_d = pos_q;
						end
					end
					MODE_DOT: begin
						mode_d = (cls_c == CLS_DIGIT) ? MODE_FRAC : MODE_DRAIN;
					end
					MODE_GT, MODE_LT: begin
						if (item.ch == CH_EQ) begin
							mode_d = MODE_IDLE;
						end else begin
							mode_d = fresh_mode_c;
							if (fresh_start_c) start_d = pos_q;
						end
					end
					MODE_DRAIN: begin
					end
					default: begin
						mode_d = fresh_mode_c;
						if (fresh_start_c) start_d = pos_q;
					end
				endcase
			end
		end
	end

	// Tokens produced by the current item.
	always_comb begin
		pre_emit_c  = 1'b0;
		pre_tok_c   = mk_tok(KIND_NUM, start_q, len_c, 8'h00);
		use_fresh_c = 1'b0;
		end_emit_c  = 1'b0;
		if (item.func == FUNC_END) begin
			end_emit_c = 1'b1;
			unique case (mode_q)
				MODE_INT, MODE_FRAC: pre_emit_c = 1'b1;
				MODE_IDENT: begin
					pre_emit_c = 1'b1;
					pre_tok_c  = mk_tok(KIND_IDENT, start_q, len_c, 8'h00);
				end
				MODE_GT: begin
					pre_emit_c = 1'b1;
					pre_tok_c  = mk_tok(KIND_GT, start_q, POS_BITS'(1), 8'h00);
				end
				MODE_LT: begin
					pre_emit_c = 1'b1;
					pre_tok_c  = mk_tok(KIND_LT, start_q, POS_BITS'(1), 8'h00);
				end
				MODE_DOT: begin
					pre_emit_c = 1'b1;
					end_emit_c = 1'b0;
					pre_tok_c  = mk_tok(KIND_ERR, start_q, POS_BITS'(1), CH_DOT);
				end
				MODE_DRAIN: end_emit_c = 1'b0;
				default: begin
				end
			endcase
		end else begin
			unique case (mode_q)
				MODE_INT: begin
					if (cls_c != CLS_DIGIT && cls_c != CLS_DOT) begin
						pre_emit_c  = 1'b1;
						use_fresh_c = 1'b1;
					end
				end
				MODE_FRAC: begin
					if (cls_c != CLS_DIGIT) begin
						pre_emit_c  = 1'b1;
						use_fresh_c = 1'b1;
					end
				end
				MODE_IDENT: begin
					pre_tok_c = mk_tok(KIND_IDENT, start_q, len_c, 8'h00);
					if (cls_c != CLS_DIGIT && cls_c != CLS_ALPHA) begin
						pre_emit_c  = 1'b1;
						use_fresh_c = 1'b1;
					end
				end
				MODE_DOT: begin
					pre_tok_c = mk_tok(KIND_ERR, start_q, POS_BITS'(1), CH_DOT);
					pre_emit_c = (cls_c != CLS_DIGIT);
				end
				MODE_GT, MODE_LT: begin
					pre_emit_c = 1'b1;
					if (item.ch == CH_EQ) begin
						pre_tok_c = mk_tok((mode_q == MODE_GT) ? KIND_GE : KIND_LE,
							start_q, POS_BITS'(2), 8'h00);
					end else begin
						pre_tok_c = mk_tok((mode_q == MODE_GT) ? KIND_GT : KIND_LT,
							start_q, POS_BITS'(1), 8'h00);
						use_fresh_c = 1'b1;
					end
				end
				MODE_DRAIN: begin
				end
				default: use_fresh_c = 1'b1;
			endcase
		end
	end

	// Pack the words of this item, oldest first, and mark the final one.
	always_comb begin
		logic       second_v;
		out_token_t second_t;
		second_v = end_emit_c | (use_fresh_c & fresh_emit_c);
		second_t = end_emit_c ? mk_tok(KIND_END, pos_q, '0, 8'h00) : fresh_tok_c;
		pair       = '0;
		pair_valid = fire & (pre_emit_c | second_v);
		if (pre_emit_c) begin
			pair.t0  = pre_tok_c;
			pair.t1  = second_t;
			pair.two = second_v;
		end else begin
			pair.t0  = second_t;
			pair.t1  = second_t;
			pair.two = 1'b0;
		end
		if (pair.two) begin
			pair.t1.last_of_run = 1'b1;
		end else begin
			pair.t0.last_of_run = 1'b1;
		end
	end

	// Scanner registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			pos_q   <= '0;
		end else begin
			mode_q  <= mode_d;
			start_q <= start_d;
			pos_q   <= pos_d;
		end
	end

	// An end item always brings the scanner back to the start of a stream.
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.func == FUNC_END |=> mode_q == MODE_IDLE && pos_q == '0)
		else $error("scanner not cleared after end item");

	// While draining, characters give no tokens.
	a_drain_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.func == FUNC_CHAR && mode_q == MODE_DRAIN |-> !pair_valid)
		else $error("token produced while draining");

	// The pending token never starts after the next character position.
	a_start_order: assert property (@(posedge clk) disable iff (!arst_n)
		start_q <= pos_q)
		else $error("token start beyond position");

endmodule

// File: hw/rtl/etl_queue.sv
// Short queue of token pairs between the scanner and the output stage.
// Register-based storage with a fill count; depends on etl_pkg.
module etl_queue
	import etl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  token_pair_t wr_data,
	input  logic        rd_en,
	output token_pair_t rd_data,
	output logic        full,
	output logic        empty
);

	token_pair_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] cnt_q;
	logic                      wr_go;
	logic                      rd_go;

	assign full    = (cnt_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign wr_go   = wr_en & ~full;
	assign rd_go   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage words.
	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_go) wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1))
				? '0 : wr_ptr_q + QUEUE_PTR_BITS'(1);
			if (rd_go) rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1))
				? '0 : rd_ptr_q + QUEUE_PTR_BITS'(1);
			if (wr_go && !rd_go) begin
				cnt_q <= cnt_q + QUEUE_CNT_BITS'(1);
			end else if (rd_go && !wr_go) begin
				cnt_q <= cnt_q - QUEUE_CNT_BITS'(1);
			end
		end
	end

	// The fill count stays within the depth.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

// File: hw/rtl/etl_back.sv
// Output stage of the lexer: hands out the words of each queued pair in turn.
// Holds one pair in a register; depends on etl_pkg.
module etl_back
	import etl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  token_pair_t q_data,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output out_token_t  result
);

	logic        valid_q;
	logic        sel_q;
	token_pair_t pair_q;
	logic        take;
	logic        pair_done;

	assign take      = ~empty & pop;
	assign pair_done = sel_q | ~pair_q.two;
	assign q_pop     = ~q_empty & (~valid_q | (take & pair_done));
	assign empty     = ~valid_q;
	assign result    = sel_q ? pair_q.t1 : pair_q.t0;

	// Pair payload register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			pair_q <= q_data;
		end
	end

	// Word select and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
			sel_q   <= 1'b0;
		end else if (take) begin
			if (pair_done) begin
				valid_q <= 1'b0;
				sel_q   <= 1'b0;
			end else begin
				sel_q <= 1'b1;
			end
		end
	end

	// The second word is only ever shown for a pair that has one.
	a_sel_two: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && sel_q |-> pair_q.two)
		else $error("second word selected for single-word pair");

	// The last word shown of a pair carries the end-of-item mark.
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && pair_done |-> result.last_of_run)
		else $error("final word of an item not marked");

endmodule

// File: hw/rtl/expression_token_lexer.sv
// Top level of the expression token lexer: scanner, pair queue, output stage.
// Depends on etl_pkg, etl_front, etl_queue and etl_back.
//
// Usage: characters of an expression arrive on the item port, one word per
// cycle while full is low, each with func low; a word with func high closes the
// stream. An input word is taken at a clock edge with push high and full
// low. Tokens leave on the result port as kind, start position, length and
// offending character; a result is present while empty is low and is taken
// at an edge with pop high.
// The scanner is combinational and writes the item's pair into the queue at
// the accepting edge; the output stage register loads it from the queue once
// it has handed out the words of the pair before.
// Throughput: one input word per cycle while full is low; results leave at
// one per cycle while pop is high, so an item that yields two tokens takes
// two pops. A four-entry pair queue absorbs such bursts, and full rises
// only when it is full: only when the receiver stalls or pairs pile up.
// Reset clears the scanner to idle with positions at zero and empties the
// queue and the output stage. A stalled receiver keeps its result steady.
module expression_token_lexer
	import etl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  in_item_t   item,
	output logic       empty,
	input  logic       pop,
	output out_token_t result
);

	logic        fire;
	logic        pair_valid;
	token_pair_t pair;
	token_pair_t q_data;
	logic        q_pop;
	logic        q_empty;

	assign fire = push & ~full;

	etl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item),
		.pair_valid (pair_valid),
		.pair       (pair)
	);

	etl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (pair_valid),
		.wr_data (pair),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.full    (full),
		.empty   (q_empty)
	);

	etl_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

// File: tb/tb_expression_token_lexer.sv
// Self-checking testbench for the expression token lexer: directed rows, then random
// expression streams, all checked by a predictor.
// Depends on etl_pkg and expression_token_lexer.
module tb_expression_token_lexer
	import etl_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no word moving on either side before the run is abandoned.
	localparam int STALL_LIMIT = 3000;
	// Length of the receiver's long hold-offs.
	localparam int HOLD_CYCLES = 300;
	// Input words, end words included, to lex after the directed phase.
	localparam int RANDOM_WORDS = 950;

	typedef struct {
		in_item_t   w;
		bit         known;
		out_token_t first;
	} row_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	in_item_t   item;
	logic       empty;
	logic       pop;
	out_token_t result;

	// Scanner state as the predictor sees it.
	mode_t       scan_st;
	logic [15:0] tok_start;
	logic [15:0] char_pos;

	out_token_t item_tokens[$];
	out_token_t lexed_tokens[$];
	row_t       plan_rows[$];
	row_t       glance_q[$];
	in_item_t   script[$];

	int mismatches;
	int results_seen;
	int lexed_items;
	bit steady;

	expression_token_lexer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Character classes used by the predictor.
	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic bit c_is_dot(logic [7:0] c);
		return c == CH_DOT;
	endfunction

	function automatic out_token_t make_token(kind_t k, logic [15:0] s, logic [15:0] l,
			logic [7:0] b, logic last);
		out_token_t t;
		t.token_kind  = k;
		t.start_pos   = s;
		t.token_len   = l;
		t.bad_char    = b;
		t.last_of_run = last;
		return t;
	endfunction

	function automatic void add_token(kind_t k, logic [15:0] s, logic [15:0] l, logic [7:0] b);
		item_tokens.push_back(make_token(k, s, l, b, 1'b0));
	endfunction

	// A character arriving with nothing pending.
	function automatic void begin_char(logic [7:0] c);
		scan_st = MODE_IDLE;
		if (is_blank(c)) begin
			scan_st = MODE_IDLE;
		end else if (is_digit(c)) begin
			scan_st = MODE_INT;
			tok_start = char_pos;
		end else if (c == CH_DOT) begin
			scan_st = MODE_DOT;
			tok_start = char_pos;
		end else if (is_letter(c) || c == CH_UNDER) begin
			scan_st = MODE_IDENT;
			tok_start = char_pos;
		end else if (c == CH_GT) begin
			scan_st = MODE_GT;
			tok_start = char_pos;
		end else if (c == CH_LT) begin
			scan_st = MODE_LT;
			tok_start = char_pos;
		end else begin
			case (c)
				CH_EQ:    add_token(KIND_EQ, char_pos, 16'd1, 8'd0);
				CH_PLUS:  add_token(KIND_PLUS, char_pos, 16'd1, 8'd0);
				CH_MINUS: add_token(KIND_MINUS, char_pos, 16'd1, 8'd0);
				CH_STAR:  add_token(KIND_STAR, char_pos, 16'd1, 8'd0);
				CH_SLASH: add_token(KIND_SLASH, char_pos, 16'd1, 8'd0);
				CH_CARET: add_token(KIND_CARET, char_pos, 16'd1, 8'd0);
				CH_LPAR:  add_token(KIND_LPAR, char_pos, 16'd1, 8'd0);
				CH_RPAR:  add_token(KIND_RPAR, char_pos, 16'd1, 8'd0);
				CH_COMMA: add_token(KIND_COMMA, char_pos, 16'd1, 8'd0);
				default: begin
					scan_st = MODE_DRAIN;
					add_token(KIND_ERR, char_pos, 16'd1, c);
				end
			endcase
		end
	endfunction

	// Work out the tokens one accepted word causes and queue them.
	function automatic void lex_item(in_item_t w);
		logic [15:0] span;
		bit          end_tok;
		item_tokens.delete();
		span = char_pos - tok_start;
		if (w.func == FUNC_END) begin
			end_tok = 1'b1;
			case (scan_st)
				MODE_INT, MODE_FRAC: add_token(KIND_NUM, tok_start, span, 8'd0);
				MODE_IDENT: add_token(KIND_IDENT, tok_start, span, 8'd0);
				MODE_GT: add_token(KIND_GT, tok_start, 16'd1, 8'd0);
				MODE_LT: add_token(KIND_LT, tok_start, 16'd1, 8'd0);
				MODE_DOT: begin
					add_token(KIND_ERR, tok_start, 16'd1, CH_DOT);
					end_tok = 1'b0;
				end
				MODE_DRAIN: end_tok = 1'b0;
				default: end_tok = 1'b1;
			endcase
			if (end_tok) begin
				add_token(KIND_END, char_pos, 16'd0, 8'd0);
			end
			scan_st = MODE_IDLE;
			tok_start = '0;
			char_pos = '0;
		end else begin
			case (scan_st)
				MODE_INT: begin
					if (c_is_dot(w.ch)) begin
						scan_st = MODE_FRAC;
					end else if (!is_digit(w.ch)) begin
						add_token(KIND_NUM, tok_start, span, 8'd0);
						begin_char(w.ch);
					end
				end
				MODE_FRAC: begin
					if (!is_digit(w.ch)) begin
						add_token(KIND_NUM, tok_start, span, 8'd0);
						begin_char(w.ch);
					end
				end
				MODE_IDENT: begin
					if (!(is_letter(w.ch) || is_digit(w.ch) || w.ch == CH_UNDER)) begin
						add_token(KIND_IDENT, tok_start, span, 8'd0);
						begin_char(w.ch);
					end
				end
				MODE_DOT: begin
					// A dot must be followed by a digit, otherwise the stream is dead.
					if (is_digit(w.ch)) begin
						scan_st = MODE_FRAC;
					end else begin
						add_token(KIND_ERR, tok_start, 16'd1, CH_DOT);
						scan_st = MODE_DRAIN;
					end
				end
				MODE_GT, MODE_LT: begin
					if (w.ch == CH_EQ) begin
						add_token((scan_st == MODE_GT) ? KIND_GE : KIND_LE, tok_start, 16'd2,
							8'd0);
						scan_st = MODE_IDLE;
					end else begin
						add_token((scan_st == MODE_GT) ? KIND_GT : KIND_LT, tok_start, 16'd1,
							8'd0);
						begin_char(w.ch);
					end
				end
				MODE_DRAIN: scan_st = MODE_DRAIN;
				default: begin_char(w.ch);
			endcase
			if (char_pos != POS_MAX) begin
				char_pos = char_pos + 16'd1;
			end
		end
		if (item_tokens.size() > 0) begin
			item_tokens[item_tokens.size() - 1].last_of_run = 1'b1;
		end
		foreach (item_tokens[i]) begin
			lexed_tokens.push_back(item_tokens[i]);
		end
	endfunction

	// One line per mismatch; the count decides the verdict.
	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic check_token(input out_token_t got, input out_token_t want,
			input string tag);
		if (got.token_kind != want.token_kind)
			flag_mismatch({tag, " token_kind"}, 32'(got.token_kind), 32'(want.token_kind));
		if (got.start_pos != want.start_pos)
			flag_mismatch({tag, " start_pos"}, 32'(got.start_pos), 32'(want.start_pos));
		if (got.token_len != want.token_len)
			flag_mismatch({tag, " token_len"}, 32'(got.token_len), 32'(want.token_len));
		if (got.bad_char != want.bad_char)
			flag_mismatch({tag, " bad_char"}, 32'(got.bad_char), 32'(want.bad_char));
		if (got.last_of_run != want.last_of_run)
			flag_mismatch({tag, " last_of_run"}, 32'(got.last_of_run),
				32'(want.last_of_run));
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Predict on every accepted input word, cross-checking the rows typed in by hand.
	always @(posedge clk) begin
		row_t g;
		if (arst_n && push && !full) begin
			lexed_items++;
			lex_item(item);
			if (glance_q.size() > 0) begin
				g = glance_q.pop_front();
				if (g.known) begin
					if (item_tokens.size() == 0) begin
						flag_mismatch("typed row with no predicted token", 0, 1);
					end else begin
						check_token(item_tokens[0], g.first, "typed row");
					end
				end
			end
		end
	end

	// Compare every word popped from the block with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (lexed_tokens.size() == 0) begin
				flag_mismatch("token with none predicted, kind", 32'(result.token_kind), 0);
			end else begin
				check_token(result, lexed_tokens.pop_front(), "dut");
			end
		end
	end

	// Receiver: random pops, plus two long hold-offs so that the block backs up.
	initial begin
		int pop_rest;
		int hold_at;
		pop_rest = 0;
		hold_at = 60;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop_rest > 0) begin
				pop <= 1'b0;
				pop_rest--;
			end else if (results_seen >= hold_at) begin
				pop <= 1'b0;
				pop_rest = HOLD_CYCLES - 1;
				hold_at = (hold_at < 600) ? 600 : 32'h7FFF_FFFF;
			end else begin
				pop <= 1'b1;
				pop_rest = steady ? 0 : pick_gap();
			end
		end
	end

	// Watchdog: give up when nothing moves for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("FAILURE");
		$finish;
	end

	// Offer one word and hold it until the block takes it.
	task automatic send_word(in_item_t w);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= w;
		push <= 1'b1;
		do @(posedge clk); while (full);
	endtask

	task automatic send_script();
		while (script.size() > 0) begin
			send_word(script.pop_front());
		end
	endtask

	function automatic in_item_t char_word(logic [7:0] c);
		in_item_t w;
		w.func = FUNC_CHAR;
		w.ch = c;
		return w;
	endfunction

	function automatic in_item_t end_word(logic [7:0] c);
		in_item_t w;
		w.func = FUNC_END;
		w.ch = c;
		return w;
	endfunction

	function automatic void plan_word(in_item_t w);
		row_t r;
		r.w = w;
		r.known = 1'b0;
		r.first = '0;
		plan_rows.push_back(r);
	endfunction

	// Typed rows are all items that give a single token.
	function automatic void plan_known(in_item_t w, kind_t k, logic [15:0] s, logic [15:0] l,
			logic [7:0] b);
		row_t r;
		r.w = w;
		r.known = 1'b1;
		r.first = make_token(k, s, l, b, 1'b1);
		plan_rows.push_back(r);
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(0, 10))
			0: return CH_EQ;
			1: return CH_PLUS;
			2: return CH_MINUS;
			3: return CH_STAR;
			4: return CH_SLASH;
			5: return CH_CARET;
			6: return CH_LPAR;
			7: return CH_RPAR;
			8: return CH_COMMA;
			9: return CH_GT;
			default: return CH_LT;
		endcase
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26) return 8'h61 + r[7:0];
		if (r < 52) return 8'h41 + r[7:0] - 8'd26;
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	// One random stream: mostly well-formed expressions, some broken or pure noise.
	function automatic void build_stream();
		int n_tok;
		int n;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) script.push_back(char_word(8'($urandom_range(0, 255))));
		end else begin
			n_tok = $urandom_range(1, 12);
			repeat (n_tok) begin
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : $urandom_range(1, 3);
						repeat (n) script.push_back(char_word(pick_digit()));
						if ($urandom_range(0, 1) == 1) begin
							script.push_back(char_word(CH_DOT));
							n = $urandom_range(0, 3);
							repeat (n) script.push_back(char_word(pick_digit()));
						end
					end
					3: begin
						script.push_back(char_word(CH_DOT));
						n = $urandom_range(1, 3);
						repeat (n) script.push_back(char_word(pick_digit()));
					end
					4, 5: begin
						script.push_back(char_word(pick_letter()));
						n = $urandom_range(0, 5);
						repeat (n) begin
							script.push_back(char_word(($urandom_range(0, 2) == 0) ?
								pick_digit() : pick_letter()));
						end
					end
					6, 7: begin
						script.push_back(char_word(pick_op()));
						if ($urandom_range(0, 3) == 0) script.push_back(char_word(CH_EQ));
					end
					8: begin
						n = $urandom_range(1, 2);
						repeat (n) script.push_back(char_word(pick_blank()));
					end
					default: begin
						// An occasional dot kills the stream unless a digit follows it.
						if ($urandom_range(0, 3) == 0) begin
							script.push_back(char_word(CH_DOT));
						end else begin
							script.push_back(char_word(pick_op()));
						end
					end
				endcase
				if ($urandom_range(0, 9) < 4) script.push_back(char_word(pick_blank()));
			end
			if (script.size() > 0 && $urandom_range(0, 4) == 0) begin
				script.insert($urandom_range(0, script.size() - 1),
					char_word(8'($urandom_range(0, 255))));
			end
		end
		script.push_back(end_word(8'($urandom_range(0, 255))));
	endfunction

	// Main sequence: reset, directed rows, random streams, drain.
	initial begin
		scan_st = MODE_IDLE;
		tok_start = '0;
		char_pos = '0;
		mismatches = 0;
		results_seen = 0;
		lexed_items = 0;
		steady = 1'b0;
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// End word straight after reset, then every operator, number forms,
		// a dot after a fraction and a flush of a pending '<' at the end.
		plan_known(end_word(8'h00), KIND_END, 16'd0, 16'd0, 8'd0);
		plan_known(char_word(CH_LPAR), KIND_LPAR, 16'd0, 16'd1, 8'd0);
		plan_word(char_word("x"));
		plan_word(char_word("9"));
		plan_word(char_word(CH_GT));
		plan_word(char_word(CH_EQ));
		plan_word(char_word("1"));
		plan_word(char_word(CH_DOT));
		plan_word(char_word("2"));
		plan_word(char_word(CH_DOT));
		plan_word(char_word("3"));
		plan_word(char_word(CH_LT));
		plan_word(char_word(CH_EQ));
		plan_word(char_word(CH_PLUS));
		plan_word(char_word(CH_STAR));
		plan_word(char_word(CH_SLASH));
		plan_word(char_word(CH_CARET));
		plan_word(char_word(CH_RPAR));
		plan_word(char_word(CH_COMMA));
		plan_word(char_word(CH_MINUS));
		plan_word(char_word(CH_EQ));
		plan_word(char_word(CH_GT));
		plan_word(char_word(CH_LT));
		plan_word(end_word(8'hFF));
		// Bad character, drained word, end word while draining.
		plan_known(char_word(8'hFF), KIND_ERR, 16'd0, 16'd1, 8'hFF);
		plan_word(char_word(8'h00));
		plan_word(end_word(8'hFF));
		// Lone dot: the error appears when the next character shows it is not a number.
		plan_word(char_word(CH_DOT));
		plan_known(char_word("a"), KIND_ERR, 16'd0, 16'd1, CH_DOT);
		plan_word(end_word(8'h00));
		foreach (plan_rows[i]) begin
			glance_q.push_back(plan_rows[i]);
			send_word(plan_rows[i].w);
		end

		// Random streams, some of them sent and popped without gaps.
		lexed_items = 0;
		while (lexed_items < RANDOM_WORDS) begin
			steady = ($urandom_range(0, 3) == 0);
			build_stream();
			send_script();
		end
		push <= 1'b0;
		steady = 1'b0;

		while (lexed_tokens.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/etl_pkg.sv
hw/rtl/etl_front.sv
hw/rtl/etl_queue.sv
hw/rtl/etl_back.sv
hw/rtl/expression_token_lexer.sv
tb/tb_expression_token_lexer.sv
